[rtl/core/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/psc_pkg.sv]
package psc_pkg;

    // config register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH    = 3'd6;

    localparam int unsigned CFG_DATA_W = 16;

    // reset values
    localparam logic signed [15:0] RST_GAIN_PROP   = 16'sd256;
    localparam logic signed [15:0] RST_GAIN_INTEG  = 16'sd256;
    localparam logic signed [15:0] RST_GAIN_DERIV  = 16'sd256;
    localparam logic        [14:0] RST_INTEG_LIMIT = 15'd26;
    localparam logic        [14:0] RST_STEER_LIMIT = 15'd7424;
    localparam logic signed [15:0] RST_OUT_LOW     = -16'sd25600;
    localparam logic signed [15:0] RST_OUT_HIGH    = 16'sd25600;

    // saturation bounds of a q7.8 word
    localparam logic signed [15:0] Q16_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q16_MIN = 16'sh8000;

    typedef logic signed [15:0] t_q16;

    typedef struct packed {
        logic signed [15:0] gain_prop;
        logic signed [15:0] gain_integ;
        logic signed [15:0] gain_deriv;
        logic        [14:0] integ_limit;
        logic        [14:0] steer_limit;
        logic signed [15:0] out_low;
        logic signed [15:0] out_high;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               clamped;
    } t_result;

endpackage

[rtl/core/psc_cfg_regs.sv]
module psc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output psc_pkg::t_cfg                       o_cfg
);
    import psc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop   <= RST_GAIN_PROP;
            r_cfg.gain_integ  <= RST_GAIN_INTEG;
            r_cfg.gain_deriv  <= RST_GAIN_DERIV;
            r_cfg.integ_limit <= RST_INTEG_LIMIT;
            r_cfg.steer_limit <= RST_STEER_LIMIT;
            r_cfg.out_low     <= RST_OUT_LOW;
            r_cfg.out_high    <= RST_OUT_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_PROP:   r_cfg.gain_prop   <= i_cfg_data;
                CFG_GAIN_INTEG:  r_cfg.gain_integ  <= i_cfg_data;
                CFG_GAIN_DERIV:  r_cfg.gain_deriv  <= i_cfg_data;
                CFG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[14:0];
                CFG_STEER_LIMIT: r_cfg.steer_limit <= i_cfg_data[14:0];
                CFG_OUT_LOW:     r_cfg.out_low     <= i_cfg_data;
                CFG_OUT_HIGH:    r_cfg.out_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/psc_term.sv]
module psc_term (
    input  logic signed [15:0] i_gain,
    input  logic signed [17:0] i_value,
    output logic signed [15:0] o_term,
    output logic               o_sat
);
    import psc_pkg::*;

    logic signed [33:0] w_prod;
    logic signed [25:0] w_shr;

    assign w_prod = 34'(i_gain) * 34'(i_value);
    // floor shift by 8 back to q7.8
    assign w_shr  = w_prod[33:8];
    assign o_sat  = !((&w_shr[25:15]) || (~|w_shr[25:15]));
    assign o_term = o_sat ? (w_shr[25] ? Q16_MIN : Q16_MAX) : w_shr[15:0];

endmodule

[rtl/core/psc_core.sv]
module psc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  psc_pkg::t_cfg      i_cfg,
    input  logic signed [15:0] i_target,
    input  logic signed [15:0] i_measured,
    output psc_pkg::t_result   o_result
);
    import psc_pkg::*;

    logic signed [15:0] r_integ;
    logic signed [16:0] r_prev;

    logic signed [16:0] w_sl;
    logic signed [16:0] w_tgt;
    logic signed [16:0] w_tgt_c;
    logic signed [17:0] w_err_full;
    logic signed [16:0] w_err;
    logic signed [17:0] w_il;
    logic signed [17:0] w_isum;
    logic signed [17:0] w_integ;
    logic signed [17:0] w_deriv;
    logic signed [15:0] w_tp, w_ti, w_td;
    logic               w_sp, w_si, w_sd;
    logic signed [17:0] w_sum;
    logic               w_sum_ovf;
    logic signed [15:0] w_sum16;
    logic signed [15:0] w_drive;
    logic               w_lim;

    // target clip
    assign w_sl  = signed'({2'b00, i_cfg.steer_limit});
    assign w_tgt = 17'(i_target);
    always_comb begin
        w_tgt_c = w_tgt;
        if (w_tgt > w_sl)  w_tgt_c = w_sl;
        if (w_tgt < -w_sl) w_tgt_c = -w_sl;
    end

    assign w_err_full = 18'(w_tgt_c) - 18'(i_measured);
    assign w_err      = w_err_full[16:0];

    // integral with symmetric clamp
    assign w_il   = signed'({3'b000, i_cfg.integ_limit});
    assign w_isum = 18'(r_integ) + 18'(w_err);
    always_comb begin
        w_integ = w_isum;
        if (w_isum > w_il)  w_integ = w_il;
        if (w_isum < -w_il) w_integ = -w_il;
    end

    assign w_deriv = 18'(w_err) - 18'(r_prev);

    psc_term u_term_p (
        .i_gain  (i_cfg.gain_prop),
        .i_value (18'(w_err)),
        .o_term  (w_tp),
        .o_sat   (w_sp)
    );

    psc_term u_term_i (
        .i_gain  (i_cfg.gain_integ),
        .i_value (w_integ),
        .o_term  (w_ti),
        .o_sat   (w_si)
    );

    psc_term u_term_d (
        .i_gain  (i_cfg.gain_deriv),
        .i_value (w_deriv),
        .o_term  (w_td),
        .o_sat   (w_sd)
    );

    assign w_sum     = 18'(w_tp) + 18'(w_ti) + 18'(w_td);
    assign w_sum_ovf = !((&w_sum[17:15]) || (~|w_sum[17:15]));
    assign w_sum16   = w_sum_ovf ? (w_sum[17] ? Q16_MIN : Q16_MAX) : w_sum[15:0];

    // low limit first, high limit wins when inverted
    always_comb begin
        w_drive = w_sum16;
        w_lim   = 1'b0;
        if (w_drive < i_cfg.out_low) begin
            w_drive = i_cfg.out_low;
            w_lim   = 1'b1;
        end
        if (w_drive > i_cfg.out_high) begin
            w_drive = i_cfg.out_high;
            w_lim   = 1'b1;
        end
    end

    assign o_result.drive   = w_drive;
    assign o_result.clamped = w_sp | w_si | w_sd | w_sum_ovf | w_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_step) begin
            r_integ <= w_integ[15:0];
            r_prev  <= w_err;
        end
    end

endmodule

[rtl/core/pid_steering_controller.sv]
// pid steering controller, one drive value per accepted sample
// path: input transfer into the input reg, then the pid result into the result reg (output valid)
// throughput: 1 sample per cycle while the output is not stalled, set by the single pass pid math between the two regs
// reset: synchronous active low; clears valids, integral and previous error,
// and loads the config registers with their defaults
module pid_steering_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [15:0]             i_angle_target,
    input  logic signed [15:0]             i_angle_measured,
    // drive output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [15:0]             o_drive,
    output logic                           o_clamped
);
    import psc_pkg::*;

    `include "assert_macros.svh"

    t_cfg    w_cfg;
    t_result w_result;

    // input register
    logic               r_in_vld;
    logic signed [15:0] r_tgt;
    logic signed [15:0] r_meas;

    // result register
    logic               r_out_vld;
    logic signed [15:0] r_drive;
    logic               r_clamped;

    logic w_in_xfer;
    logic w_move;

    // the sample in the input reg moves on when the result reg is free or drains
    assign w_move     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_move;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    psc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // pid math; controller state advances once per moved sample
    psc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_move),
        .i_cfg      (w_cfg),
        .i_target   (r_tgt),
        .i_measured (r_meas),
        .o_result   (w_result)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (w_move) begin
            r_in_vld <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_tgt  <= i_angle_target;
            r_meas <= i_angle_measured;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_move) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_drive   <= w_result.drive;
            r_clamped <= w_result.clamped;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;

    // a sample that cannot move on stays in the input reg
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (r_in_vld && !w_move) |=> r_in_vld, "input sample lost")
    // a moved sample always lands in the result reg
    `ASSERT_CLK(a_move_fills, i_clk, i_rst_n, w_move |=> r_out_vld, "moved sample not held as result")
    // both stages are empty right after reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> (!r_in_vld && !r_out_vld), "valid after reset")

endmodule

[sim/drive_checker.sv]
// watches the config port and both channels of the steering controller,
// predicts each drive result and compares it with what comes out
module drive_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic signed [15:0]             i_angle_target,
    input  logic signed [15:0]             i_angle_measured,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic signed [15:0]             i_drive,
    input  logic                           i_clamped,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_clamped_results
);

    localparam int PRINT_CAP = 40;

    // shadow copy of the register file
    logic signed [15:0] gain_p, gain_i, gain_d;
    logic        [14:0] integ_lim, steer_lim;
    logic signed [15:0] drive_lo, drive_hi;

    // loop state
    logic signed [15:0] integ_acc;
    logic signed [16:0] prev_err;

    psc_pkg::t_result drive_expect_q[$];

    int n_fail    = 0;
    int n_results = 0;
    int n_clamped = 0;

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_results         = 0;
        o_clamped_results = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_fail++;
        if (n_fail <= PRINT_CAP)
            $display("drive_checker: result %0d %s: got %0d, expected %0d",
                     n_results, what, got, want);
    endtask

    function automatic longint sat_q16(input longint v, inout bit hit);
        if (v > longint'(psc_pkg::Q16_MAX)) begin
            hit = 1'b1;
            return longint'(psc_pkg::Q16_MAX);
        end
        if (v < longint'(psc_pkg::Q16_MIN)) begin
            hit = 1'b1;
            return longint'(psc_pkg::Q16_MIN);
        end
        return v;
    endfunction

    // q7.8 gain times q7.8 value, floored back to q7.8
    function automatic longint gain_term(input logic signed [15:0] g, input longint v,
                                         inout bit hit);
        longint prod;
        prod = longint'(g) * v;
        return sat_q16(prod >>> 8, hit);
    endfunction

    // one control tick: updates integral and previous error
    function automatic psc_pkg::t_result predict_drive(input logic signed [15:0] tgt_in,
                                                        input logic signed [15:0] meas_in);
        longint tgt, err, integ, deriv, sum, lim;
        bit hit;
        psc_pkg::t_result res;
        hit = 1'b0;
        tgt = longint'(tgt_in);
        lim = longint'(steer_lim);
        if (tgt > lim) tgt = lim;
        if (tgt < -lim) tgt = -lim;
        err = tgt - longint'(meas_in);

        integ = longint'(integ_acc) + err;
        lim = longint'(integ_lim);
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;
        integ_acc = integ[15:0];

        deriv = err - longint'(prev_err);
        prev_err = err[16:0];

        sum = gain_term(gain_p, err, hit) + gain_term(gain_i, integ, hit)
            + gain_term(gain_d, deriv, hit);
        sum = sat_q16(sum, hit);
        if (sum < longint'(drive_lo)) begin
            sum = longint'(drive_lo);
            hit = 1'b1;
        end
        if (sum > longint'(drive_hi)) begin
            sum = longint'(drive_hi);
            hit = 1'b1;
        end
        res.drive   = sum[15:0];
        res.clamped = hit;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        psc_pkg::t_result want;
        if (!i_rst_n) begin
            gain_p    = psc_pkg::RST_GAIN_PROP;
            gain_i    = psc_pkg::RST_GAIN_INTEG;
            gain_d    = psc_pkg::RST_GAIN_DERIV;
            integ_lim = psc_pkg::RST_INTEG_LIMIT;
            steer_lim = psc_pkg::RST_STEER_LIMIT;
            drive_lo  = psc_pkg::RST_OUT_LOW;
            drive_hi  = psc_pkg::RST_OUT_HIGH;
            integ_acc = '0;
            prev_err  = '0;
            drive_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    psc_pkg::CFG_GAIN_PROP:   gain_p    = i_cfg_data;
                    psc_pkg::CFG_GAIN_INTEG:  gain_i    = i_cfg_data;
                    psc_pkg::CFG_GAIN_DERIV:  gain_d    = i_cfg_data;
                    psc_pkg::CFG_INTEG_LIMIT: integ_lim = i_cfg_data[14:0];
                    psc_pkg::CFG_STEER_LIMIT: steer_lim = i_cfg_data[14:0];
                    psc_pkg::CFG_OUT_LOW:     drive_lo  = i_cfg_data;
                    psc_pkg::CFG_OUT_HIGH:    drive_hi  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                drive_expect_q.push_back(predict_drive(i_angle_target, i_angle_measured));
            if (i_out_valid && i_out_ready) begin
                n_results++;
                if (i_clamped) n_clamped++;
                if (drive_expect_q.size() == 0) begin
                    report_mismatch("arrived with nothing expected", i_drive, 0);
                end else begin
                    want = drive_expect_q.pop_front();
                    if (i_drive !== want.drive)
                        report_mismatch("drive", i_drive, $signed(want.drive));
                    if (i_clamped !== want.clamped)
                        report_mismatch("clamped", i_clamped, want.clamped);
                end
            end
        end
        o_fail_count      <= n_fail;
        o_pending         <= drive_expect_q.size();
        o_results         <= n_results;
        o_clamped_results <= n_clamped;
    end

endmodule

[sim/tb.sv]
// top of the steering controller regression: stimulus, stall patterns and verdict
module tb;
    import psc_pkg::*;

    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int N_RANDOM     = 2000;
    localparam int N_PHASES     = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;     // two register stages plus margin
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 600;   // result count that starts the long hold-off

    localparam t_q16 EXTREMES [6] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff,
                                      16'sd7424};

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_RARE, RX_PERIODIC} t_rx_mode;

    // block inputs, all known from time zero
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    t_q16                  i_angle_target   = '0;
    t_q16                  i_angle_measured = '0;
    logic                  i_out_ready      = 1'b0;

    // block outputs
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_q16                  o_drive;
    logic                  o_clamped;

    // checker status
    int fail_count, pending, results_seen, n_clamped;

    // run bookkeeping
    int unsigned cycle_count = 0;
    int          n_sent      = 0;
    int          n_settings  = 0;
    int          n_in_stalls = 0;
    int          burst_left  = 1;
    int          gap_max     = 0;
    t_rx_mode    rx_mode     = RX_ALWAYS;
    bit          hold_done   = 1'b0;

    pid_steering_controller dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_index,
        .i_cfg_data,
        .i_in_valid,
        .o_in_ready,
        .i_angle_target,
        .i_angle_measured,
        .o_out_valid,
        .i_out_ready,
        .o_drive,
        .o_clamped
    );

    drive_checker chk (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_index,
        .i_cfg_data,
        .i_in_valid,
        .i_in_ready        (o_in_ready),
        .i_angle_target,
        .i_angle_measured,
        .i_out_valid       (o_out_valid),
        .i_out_ready,
        .i_drive           (o_drive),
        .i_clamped         (o_clamped),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results         (results_seen),
        .o_clamped_results (n_clamped)
    );

    // 8 unit clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // cycles where the sender offers and the block pushes back
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_ready) n_in_stalls++;
    end

    // one register write per edge; the enable is dropped by the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // full register set, optionally followed by a write to the unused index
    task automatic program_regs(input logic [15:0] gp, gi, gd, il, sl, lo, hi,
                                input bit with_spare);
        write_reg(CFG_GAIN_PROP, gp);
        write_reg(CFG_GAIN_INTEG, gi);
        write_reg(CFG_GAIN_DERIV, gd);
        write_reg(CFG_INTEG_LIMIT, il);
        write_reg(CFG_STEER_LIMIT, sl);
        write_reg(CFG_OUT_LOW, lo);
        write_reg(CFG_OUT_HIGH, hi);
        // last, so an alias onto a real register would corrupt it
        if (with_spare) write_reg(CFG_SPARE, 16'($urandom));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // stop offering and wait until every drive result has come back
    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one sample, hold it until its transfer, then maybe open a gap
    task automatic offer_sample(input t_q16 tgt, input t_q16 meas);
        i_angle_target   <= tgt;
        i_angle_measured <= meas;
        i_in_valid       <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gap_max > 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
    endtask

    // mostly tracking samples near each other so the integral and derivative
    // stay in play, plus full range noise and edge values
    task automatic random_sample();
        t_q16 tgt, meas;
        case ($urandom_range(0, 7))
            6: begin
                tgt  = 16'($urandom);
                meas = 16'($urandom);
            end
            7: begin
                tgt  = EXTREMES[$urandom_range(0, 5)];
                meas = EXTREMES[$urandom_range(0, 5)];
            end
            default: begin
                tgt  = t_q16'(int'($urandom_range(0, 16384)) - 8192);
                meas = t_q16'(int'(tgt) + int'($urandom_range(0, 1024)) - 512);
            end
        endcase
        offer_sample(tgt, meas);
    endtask

    // one random register setting, extremes weighted in
    task automatic random_config();
        logic        [15:0] gains [3];
        logic        [15:0] il, sl;
        logic signed [15:0] lo, hi, a, b;
        int                 m;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0:       gains[k] = 16'h8000;
                1:       gains[k] = 16'h7fff;
                2:       gains[k] = 16'($urandom);
                default: gains[k] = 16'(int'($urandom_range(0, 1536)) - 768);
            endcase
        end
        case ($urandom_range(0, 4))
            0:       il = 16'd0;
            1:       il = 16'h7fff;
            2:       il = 16'($urandom_range(0, 32767));
            3:       il = 16'($urandom);   // top bit is beyond the register
            default: il = 16'($urandom_range(0, 2048));
        endcase
        case ($urandom_range(0, 3))
            0:       sl = 16'd0;
            1:       sl = 16'h7fff;
            2:       sl = 16'($urandom);
            default: sl = 16'($urandom_range(1024, 12000));
        endcase
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                lo = 16'sh8000;
                hi = 16'sh7fff;
            end
            1: begin
                // inverted limits, low above high
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            2: begin
                lo = (a > b) ? b : a;
                hi = (a > b) ? a : b;
            end
            default: begin
                m  = $urandom_range(256, 32767);
                lo = 16'(-m);
                hi = 16'(m);
            end
        endcase
        program_regs(gains[0], gains[1], gains[2], il, sl, lo, hi, 1'($urandom_range(0, 1)));
    endtask

    // receiver: per-phase stall pattern, one long hold-off while the sender keeps going
    initial begin : receiver
        int unsigned tick;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (!hold_done && results_seen >= HOLD_AT) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:   i_out_ready <= 1'b1;
                    RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                    RX_RARE:     i_out_ready <= ($urandom_range(0, 7) != 0);
                    RX_PERIODIC: i_out_ready <= ((tick % 7) < 3);
                    default:     i_out_ready <= 1'b1;
                endcase
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("pid_steering_controller regression: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: zero, small steps, integral clamp, target clip
        // (clip and integral clamp alone leave clamped low), full scale saturation
        n_settings = 1;
        offer_sample(0, 0);
        offer_sample(100, 0);
        offer_sample(-100, 0);
        offer_sample(10000, 7424);
        offer_sample(16'sh7fff, 16'sh8000);
        offer_sample(16'sh8000, 16'sh7fff);
        offer_sample(-1, -1);
        offer_sample(1, 0);

        // most negative gains, widest limits
        go_idle();
        program_regs(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                     16'h8000, 16'h7fff, 1'b0);
        offer_sample(16'sh7fff, 16'sh8000);
        offer_sample(16'sh8000, 16'sh7fff);
        offer_sample(0, 0);
        offer_sample(1, 0);
        offer_sample(-1, 0);

        // most positive gains, zero limits on target and integral
        go_idle();
        program_regs(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000,
                     16'h8000, 16'h7fff, 1'b0);
        offer_sample(16'sh7fff, 0);
        offer_sample(0, 16'sh7fff);
        offer_sample(0, 16'sh8000);

        // unit gains with inverted output limits; the unused index gets all ones
        go_idle();
        program_regs(16'h0100, 16'h0100, 16'h0100, 16'h001a, 16'h1d00,
                     16'h0200, 16'hfe00, 1'b0);
        write_reg(CFG_SPARE, 16'hffff);
        i_cfg_we <= 1'b0;
        offer_sample(0, 0);
        offer_sample(1000, 0);
        offer_sample(-1000, 0);

        // random part, one register setting per phase; the first phase runs flat out
        for (int p = 0; p < N_PHASES; p++) begin
            go_idle();
            random_config();
            if (p == 0) begin
                rx_mode = RX_ALWAYS;
                gap_max = 0;
            end else begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            repeat (N_RANDOM / N_PHASES) random_sample();
        end
        go_idle();

        $display("tb: %0d samples over %0d register settings, %0d drive results, %0d clamped",
                 n_sent, n_settings, results_seen, n_clamped);
        $display("tb: input held back %0d cycles, one output hold-off of %0d cycles",
                 n_in_stalls, LONG_HOLD);
        if (fail_count == 0)
            $display("pid_steering_controller regression: pass");
        else
            $display("pid_steering_controller regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/psc_pkg.sv
rtl/core/psc_cfg_regs.sv
rtl/core/psc_term.sv
rtl/core/psc_core.sv
rtl/core/pid_steering_controller.sv
sim/drive_checker.sv
sim/tb.sv
